// ===== rtl/htfc_pkg.sv =====
// package for the humidity/temperature frame checker
// holds result codes, frame constants, the result record and the crc-8 byte step
// no dependencies
`default_nettype none

package htfc_pkg;

   // result codes
   typedef enum logic [1:0] {
      OUTCOME_OK      = 2'd0,
      OUTCOME_CRC_ERR = 2'd1,
      OUTCOME_BUSY    = 2'd2
   } outcome_type;

   // crc-8 definition
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // poll byte busy flag position
   localparam int BUSY_BIT = 7;

   // frame positions: 0 idle, 1..7 next byte is frame byte (position - 1)
   localparam logic [3:0] POS_IDLE      = 4'd0;
   localparam logic [3:0] POS_FIRST     = 4'd1;
   localparam logic [3:0] POS_FIRST_PAY = 4'd2;
   localparam logic [3:0] POS_LAST_CRC  = 4'd6;
   localparam logic [3:0] POS_LAST      = 4'd7;

   // result buffer depth
   localparam int RSP_DEPTH = 3;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [1:0]  outcome;
      logic [19:0] humidity_raw;
      logic [19:0] temperature_raw;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type result;
   } push_type;

   // one byte of crc-8, msb first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/htfc_frame_track.sv =====
// input register and frame tracker: crc, payload capture and result decision
// uses htfc_pkg
`default_nettype none

module htfc_frame_track (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        rx_byte,
   input  wire logic              frame_start,
   output logic                   busy_slot,
   output htfc_pkg::push_type     push
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_start_ff;
   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  crc_ff, crc_in;
   logic [39:0] payload_ff, payload_in;

   // input register
   assign in_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_byte_ff  <= rx_byte;
         in_start_ff <= frame_start;
      end
   end

   assign busy_slot = in_valid_ff;

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= htfc_pkg::POS_IDLE;
         crc_ff     <= htfc_pkg::CRC_INIT;
         payload_ff <= '0;
      end else begin
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         payload_ff <= payload_in;
      end
   end

   // next state and result for the registered byte
   always_comb begin
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      payload_in  = payload_ff;
      push        = '0;
      if (in_valid_ff) begin
         if (in_start_ff) begin
            // poll byte, also restarts a partial frame
            crc_in     = htfc_pkg::CRC_INIT;
            payload_in = '0;
            if (in_byte_ff[htfc_pkg::BUSY_BIT]) begin
               pos_in              = htfc_pkg::POS_IDLE;
               push.valid          = 1'b1;
               push.result.outcome = htfc_pkg::OUTCOME_BUSY;
            end else begin
               pos_in = htfc_pkg::POS_FIRST;
            end
         end else if (pos_ff == htfc_pkg::POS_IDLE || pos_ff > htfc_pkg::POS_LAST) begin
            // stray byte while idle
            pos_in = htfc_pkg::POS_IDLE;
         end else if (pos_ff <= htfc_pkg::POS_LAST_CRC) begin
            crc_in = htfc_pkg::crc8_byte(crc_ff, in_byte_ff);
            if (pos_ff >= htfc_pkg::POS_FIRST_PAY) begin
               payload_in = {payload_ff[31:0], in_byte_ff};
            end
            pos_in = pos_ff + 4'd1;
         end else begin
            // last byte carries the crc
            pos_in     = htfc_pkg::POS_IDLE;
            push.valid = 1'b1;
            if (crc_ff != in_byte_ff) begin
               push.result.outcome = htfc_pkg::OUTCOME_CRC_ERR;
            end else begin
               push.result.outcome         = htfc_pkg::OUTCOME_OK;
               push.result.humidity_raw    = payload_ff[39:20];
               push.result.temperature_raw = payload_ff[19:0];
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/htfc_rsp_fifo.sv =====
// small result buffer between the frame tracker and the result channel
// uses htfc_pkg
`default_nettype none

module htfc_rsp_fifo (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire htfc_pkg::push_type            push,
   input  wire logic                          pop,
   output logic                               not_empty,
   output htfc_pkg::result_type               head,
   output logic [htfc_pkg::RSP_CNT_W-1:0]     count
);

   localparam int PtrW = htfc_pkg::RSP_PTR_W;
   localparam int CntW = htfc_pkg::RSP_CNT_W;
   localparam logic [PtrW-1:0] LastIdx = PtrW'(htfc_pkg::RSP_DEPTH - 1);

   htfc_pkg::result_type mem_ff [htfc_pkg::RSP_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_pop;

   assign do_pop = pop && (count_ff != '0);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == LastIdx) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastIdx) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.result;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

`default_nettype wire

// ===== rtl/humidity_temp_frame_checker_unit.sv =====
// top level of the humidity/temperature sensor frame checker
// uses htfc_pkg, htfc_frame_track, htfc_rsp_fifo
//
// usage:
//   req channel: one sensor byte per item (req_rx_byte) with req_frame_start
//   marking the status poll byte. a busy poll byte yields a busy result; an
//   idle poll byte opens a 7-byte frame, crc-8 (0x31, init 0xff) runs over
//   frame bytes 0..5 and byte 6 is compared against it.
//   rsp channel: one result per busy poll or completed frame, with outcome,
//   20-bit raw humidity and 20-bit raw temperature (zero unless outcome ok).
//   throughput: one byte per cycle, sustained while rsp_ready is high; the
//   crc step is a single unrolled byte update between the input register and
//   the result buffer. path: an accepted byte is held in the input register,
//   and its result is then written into the buffer that drives the rsp port.
//   stalls: results sit in a 3-entry buffer; req_ready drops only when the
//   buffer plus the byte in flight could fill it, and never depends on
//   rsp_ready in the same cycle.
//   reset: synchronous; clears the frame position (idle), the crc and the
//   buffer, so no result is pending afterwards.
`default_nettype none

module humidity_temp_frame_checker_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_frame_start,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_outcome,
   output logic [19:0]      rsp_humidity_raw,
   output logic [19:0]      rsp_temperature_raw
);

   localparam int CntW = htfc_pkg::RSP_CNT_W;

   logic                              accept;
   logic                              busy_slot;
   htfc_pkg::push_type                push;
   htfc_pkg::result_type              head;
   logic [CntW-1:0]                   count;
   logic [CntW:0]                     committed;

   // room for the buffered results, the byte in flight and this one
   assign committed = {1'b0, count} + {{CntW{1'b0}}, busy_slot};
   assign req_ready = (committed <= (CntW+1)'(htfc_pkg::RSP_DEPTH - 1));
   assign accept    = req_valid && req_ready;

   htfc_frame_track u_track (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_byte     (req_rx_byte),
      .frame_start (req_frame_start),
      .busy_slot   (busy_slot),
      .push        (push)
   );

   htfc_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_ready),
      .not_empty (rsp_valid),
      .head      (head),
      .count     (count)
   );

   assign rsp_outcome         = head.outcome;
   assign rsp_humidity_raw    = head.humidity_raw;
   assign rsp_temperature_raw = head.temperature_raw;

endmodule

`default_nettype wire

// ===== rtl/htfc_checker.sv =====
// port-level checks for the humidity/temperature frame checker
// uses htfc_pkg; bound to humidity_temp_frame_checker_unit
`default_nettype none

module htfc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_outcome,
   input wire logic [19:0] rsp_humidity_raw,
   input wire logic [19:0] rsp_temperature_raw
);

   // nothing pending right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // an offered item stays offered until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("offered item withdrawn");

   // a stalled result stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_outcome)
         && $stable(rsp_humidity_raw) && $stable(rsp_temperature_raw))
      else $error("stalled result changed");

   // only the defined codes leave the block
   a_outcome_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_outcome == htfc_pkg::OUTCOME_OK
         || rsp_outcome == htfc_pkg::OUTCOME_CRC_ERR
         || rsp_outcome == htfc_pkg::OUTCOME_BUSY)
      else $error("undefined outcome code");

   // failed results carry no measurement
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome != htfc_pkg::OUTCOME_OK
         |-> rsp_humidity_raw == '0 && rsp_temperature_raw == '0)
      else $error("measurement on a failed result");

endmodule

bind humidity_temp_frame_checker_unit htfc_checker u_htfc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_outcome         (rsp_outcome),
   .rsp_humidity_raw    (rsp_humidity_raw),
   .rsp_temperature_raw (rsp_temperature_raw)
);

`default_nettype wire
